@@ rtl/ipal_pkg.sv @@
// ----------------------------------------------------------------------------
// ipal_pkg - shared types and constants for the address allowlist table
// Holds the table depth, operation and status codes, the in/out word
// structs, the cell control struct and the sequencer state type.
// ----------------------------------------------------------------------------
package ipal_pkg;

  // table size and derived widths
  localparam int TABLE_DEPTH   = 16;
  localparam int CNT_W         = $clog2(TABLE_DEPTH + 1);
  localparam int ADDR_W        = 32;
  localparam int FUNC_W        = 2;
  localparam int STATUS_W      = 2;
  localparam int ENTRY_TOTAL_W = 5;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-3:0] REG_CLOSED_MODE = '0;

  // operation codes
  localparam logic [FUNC_W-1:0] FUNC_CHECK  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_DUPLICATE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd3;

  // input word
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [ADDR_W-1:0] ip_address;
  } in_word_t;

  // result word
  typedef struct packed {
    logic                     allowed;
    logic [STATUS_W-1:0]      status;
    logic [ENTRY_TOTAL_W-1:0] entry_total;
  } out_word_t;

  // per-cell control from the sequencer
  typedef struct packed {
    logic valid;
    logic load;
    logic shift;
  } cell_ctrl_t;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_UPD
  } state_t;

endpackage

@@ rtl/ipal_cell.sv @@
// ----------------------------------------------------------------------------
// ipal_cell - one slot of the allowlist
// Holds one address, compares it against the broadcast key and passes the
// running any-match flag and its stored address on to its neighbours.
// ----------------------------------------------------------------------------
module ipal_cell
  import ipal_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cell_ctrl_t        ctrl,
  input  logic [ADDR_W-1:0] key,
  input  logic [ADDR_W-1:0] upper_entry,
  input  logic              hit_in,
  output logic [ADDR_W-1:0] entry,
  output logic              hit_out
);

  logic [ADDR_W-1:0] entry_r;
  logic              match_r;

  // stored address: append writes the key, remove takes the upper neighbour
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      entry_r <= key;
    end else if (ctrl.shift) begin
      entry_r <= upper_entry;
    end
  end

  // compare against the key, only for slots below the count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else begin
      match_r <= ctrl.valid && (entry_r == key);
    end
  end

  // a match here or in any lower slot
  assign hit_out = hit_in | match_r;
  assign entry   = entry_r;

endmodule

@@ rtl/ipal_cfg.sv @@
// ----------------------------------------------------------------------------
// ipal_cfg - configuration register block
// APB-style slave holding the closed-mode bit; writes to other offsets are
// dropped and read back as zero.
// ----------------------------------------------------------------------------
module ipal_cfg
  import ipal_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic                  closed_mode
);

  logic closed_mode_r;
  logic reg_hit;

  // register select ignores byte lanes
  assign reg_hit = (paddr[CFG_ADDR_W-1:2] == REG_CLOSED_MODE);

  // closed-mode bit, only bit 0 kept
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      closed_mode_r <= 1'b0;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      closed_mode_r <= pwdata[0];
    end
  end

  // read back
  always_comb begin
    prdata = '0;
    if (reg_hit) begin
      prdata[0] = closed_mode_r;
    end
  end

  assign pready      = 1'b1;
  assign closed_mode = closed_mode_r;

endmodule

@@ rtl/ip_allowlist_table_top.sv @@
// ----------------------------------------------------------------------------
// ip_allowlist_table_top - IPv4 address allowlist
// Each word passes through capture, compare in every cell at once, and
// update of the row of cells with the result registered. The result
// strobe is registered from the update state; a new word is taken only
// when busy is low, once the compare-then-update pass over the row is done.
// Reset empties the list and sets open mode at once; no clearing pass.
// The receiver cannot stall: out_strobe is high for exactly one cycle.
// ----------------------------------------------------------------------------
module ip_allowlist_table_top
  import ipal_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // command channel
  input  logic                  start,
  input  in_word_t              in_data,
  output logic                  busy,
  // result channel
  output logic                  out_strobe,
  output out_word_t             out_data,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  state_t            state_r, state_nxt;
  logic [FUNC_W-1:0] func_r;
  logic [ADDR_W-1:0] key_r;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              out_strobe_r;
  out_word_t         out_data_r, out_data_nxt;
  logic              closed_mode;
  logic              accept;
  logic              any_hit;
  logic              upd_add_ok;
  logic              upd_remove_ok;

  cell_ctrl_t        cell_ctrl [TABLE_DEPTH];
  logic [ADDR_W-1:0] entry_w   [TABLE_DEPTH];
  logic [ADDR_W-1:0] upper_w   [TABLE_DEPTH];
  logic              hit_chain [TABLE_DEPTH+1];

  // configuration registers
  ipal_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .closed_mode (closed_mode)
  );

  assign accept       = start && !busy;
  assign hit_chain[0] = 1'b0;
  assign any_hit      = hit_chain[TABLE_DEPTH];

  // row of cells, slot 0 at the bottom
  for (genvar j = 0; j < TABLE_DEPTH; j++) begin : g_cell
    if (j == TABLE_DEPTH - 1) begin : g_top
      assign upper_w[j] = entry_w[j];
    end else begin : g_mid
      assign upper_w[j] = entry_w[j+1];
    end

    assign cell_ctrl[j].valid = (CNT_W'(j) < count_r);
    assign cell_ctrl[j].load  = upd_add_ok && (CNT_W'(j) == count_r);
    assign cell_ctrl[j].shift = upd_remove_ok && hit_chain[j+1];

    ipal_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (cell_ctrl[j]),
      .key         (key_r),
      .upper_entry (upper_w[j]),
      .hit_in      (hit_chain[j]),
      .entry       (entry_w[j]),
      .hit_out     (hit_chain[j+1])
    );
  end

  // capture the command word
  always_ff @(posedge clk) begin
    if (accept) begin
      func_r <= in_data.func;
      key_r  <= in_data.ip_address;
    end
  end

  // state, count and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      out_strobe_r <= (state_r == S_UPD);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_UPD) begin
      out_data_r <= out_data_nxt;
    end
  end

  // sequencer and update decision
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    upd_add_ok    = 1'b0;
    upd_remove_ok = 1'b0;
    out_data_nxt  = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        state_nxt = S_UPD;
      end
      S_UPD: begin
        state_nxt = S_IDLE;
        unique case (func_r)
          FUNC_CHECK: begin
            out_data_nxt.allowed = !closed_mode || any_hit;
          end
          FUNC_ADD: begin
            if (any_hit) begin
              out_data_nxt.status = STATUS_DUPLICATE;
            end else if (count_r >= CNT_W'(TABLE_DEPTH)) begin
              out_data_nxt.status = STATUS_FULL;
            end else begin
              upd_add_ok = 1'b1;
              count_nxt  = count_r + 1'b1;
            end
          end
          FUNC_REMOVE: begin
            if (any_hit) begin
              upd_remove_ok = 1'b1;
              count_nxt     = count_r - 1'b1;
            end else begin
              out_data_nxt.status = STATUS_NOT_FOUND;
            end
          end
          default: begin
          end
        endcase
        out_data_nxt.entry_total = ENTRY_TOTAL_W'(count_nxt);
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

  // checks
  a_strobe_after_update: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> $past(state_r == S_UPD))
    else $error("result strobe without an update cycle");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("accepted word did not raise busy");

  a_add_grows: assert property (@(posedge clk) disable iff (!rst_n)
    upd_add_ok |=> (count_r == CNT_W'($past(count_r) + 1'b1)))
    else $error("successful add did not grow the count");

endmodule
